### rtl/mh64_pkg.sv
// Package with the types, codes and constants shared by the streaming MurmurHash64A block.
package mh64_pkg;

  localparam logic [63:0] MIX_MULT   = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MIX_MULT_LO = MIX_MULT[31:0];
  localparam logic [31:0] MIX_MULT_HI = MIX_MULT[63:32];
  localparam int unsigned MIX_SHIFT  = 47;

  typedef enum logic [1:0] {
    IK_NONE,
    IK_TAIL,
    IK_FULL
  } item_kind_t;

  typedef struct packed {
    logic [63:0] word;
    item_kind_t  kind;
    logic        first;
    logic        last;
    logic [30:0] length;
  } q_entry_t;

  typedef struct packed {
    logic     vld;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    MS_LO_LO,
    MS_LO_HI,
    MS_HI_LO
  } mul_step_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEN_W,
    BK_BODY,
    BK_K1_W,
    BK_K2_W,
    BK_H_W,
    BK_FIN,
    BK_FOUT_W
  } back_state_t;

endpackage

### rtl/mh64_ifs.sv
// Channel interfaces for message words, hash results and the seed register write.
interface mh64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  valid_bytes;
  logic        first_word;
  logic        last_word;
  logic [30:0] message_length;

  modport source (output valid, data_word, valid_bytes, first_word, last_word,
                  message_length, input ready);
  modport sink (input valid, data_word, valid_bytes, first_word, last_word,
                message_length, output ready);
endinterface

interface mh64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

interface mh64_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_seed;

  modport source (output valid, hash_seed, input ready);
  modport sink (input valid, hash_seed, output ready);
endinterface

### rtl/mh64_mul.sv
// Multi-cycle multiplier by the mixing constant, modulo 2^64, on one 32x32 multiplier.
module mh64_mul
  import mh64_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  mul_step_t   step_r, step_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] p0_r, p0_nxt;
  logic [31:0] cross_r, cross_nxt;
  logic [31:0] op_a;
  logic [31:0] op_c;
  logic [63:0] prod;

  always_comb begin
    op_a = a_r[31:0];
    op_c = MIX_MULT_LO;
    unique case (step_r)
      MS_LO_LO: begin
        op_a = a_r[31:0];
        op_c = MIX_MULT_LO;
      end
      MS_LO_HI: begin
        op_a = a_r[31:0];
        op_c = MIX_MULT_HI;
      end
      MS_HI_LO: begin
        op_a = a_r[63:32];
        op_c = MIX_MULT_LO;
      end
      default: begin
        op_a = a_r[31:0];
        op_c = MIX_MULT_LO;
      end
    endcase
  end

  assign prod = {32'd0, op_a} * {32'd0, op_c};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    a_nxt     = a_r;
    p0_nxt    = p0_r;
    cross_nxt = cross_r;
    if (busy_r) begin
      unique case (step_r)
        MS_LO_LO: begin
          p0_nxt   = prod;
          step_nxt = MS_LO_HI;
        end
        MS_LO_HI: begin
          cross_nxt = prod[31:0];
          step_nxt  = MS_HI_LO;
        end
        MS_HI_LO: begin
          cross_nxt = cross_r + prod[31:0];
          busy_nxt  = 1'b0;
          done_nxt  = 1'b1;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end else if (req.start) begin
      a_nxt    = req.a;
      step_nxt = MS_LO_LO;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= MS_LO_LO;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r     <= a_nxt;
    p0_r    <= p0_nxt;
    cross_r <= cross_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = p0_r + {cross_r, 32'd0};

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("multiplier finished without a running product");

  a_no_start_while_busy_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == MS_HI_LO) |=> (!busy_r && done_r))
    else $error("multiplier did not finish after its last step");

  a_busy_done_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("multiplier busy and done together");

endmodule

### rtl/mh64_front.sv
// Front end: accepts message words, masks tails, classifies them and queues them.
module mh64_front
  import mh64_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  mh64_in_if.sink       in_ch,
  output q_head_t       head,
  input  logic          pop
);

  q_entry_t    q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  logic [63:0] byte_mask;
  q_entry_t    entry;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  // A byte lane is kept when its index is below the valid byte count.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[i*8 +: 8] = (4'(i) < in_ch.valid_bytes) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    entry.first  = in_ch.first_word;
    entry.last   = in_ch.last_word;
    entry.length = in_ch.message_length;
    if (in_ch.valid_bytes[3]) begin
      entry.kind = IK_FULL;
      entry.word = in_ch.data_word;
    end else if (in_ch.valid_bytes == 4'd0) begin
      entry.kind = IK_NONE;
      entry.word = in_ch.data_word;
    end else begin
      entry.kind = IK_TAIL;
      entry.word = in_ch.data_word & byte_mask;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

  assign head.vld   = (cnt_r != 2'd0);
  assign head.entry = q_r[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("queue count beyond its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != 2'd0))
    else $error("queue popped while empty");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with the count");

endmodule

### rtl/mh64_back.sv
// Back end: sequences the hash updates and the finalizer through the shared multiplier.
module mh64_back
  import mh64_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic [63:0]   seed,
  input  q_head_t       head,
  output logic          pop,
  output mul_req_t      mul_req,
  input  mul_rsp_t      mul_rsp,
  mh64_out_if.source    out_ch
);

  back_state_t state_r, state_nxt;
  q_entry_t    cur_r, cur_nxt;
  logic [63:0] h_r, h_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;
  logic        load_out;
  logic [63:0] res;
  logic        cur_is_full;

  assign res         = mul_rsp.result;
  assign cur_is_full = (cur_r.kind == IK_FULL);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head.vld) begin
          state_nxt = head.entry.first ? BK_LEN_W : BK_BODY;
        end
      end
      BK_LEN_W: begin
        if (mul_rsp.done) state_nxt = BK_BODY;
      end
      BK_BODY: begin
        unique case (cur_r.kind)
          IK_FULL: state_nxt = BK_K1_W;
          IK_TAIL: state_nxt = BK_H_W;
          default: state_nxt = BK_FIN;
        endcase
      end
      BK_K1_W: begin
        if (mul_rsp.done) state_nxt = BK_K2_W;
      end
      BK_K2_W: begin
        if (mul_rsp.done) state_nxt = BK_H_W;
      end
      BK_H_W: begin
        if (mul_rsp.done) state_nxt = BK_FIN;
      end
      BK_FIN: begin
        if (!cur_r.last) begin
          state_nxt = BK_IDLE;
        end else if (!out_vld_r) begin
          state_nxt = BK_FOUT_W;
        end
      end
      BK_FOUT_W: begin
        if (mul_rsp.done) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    pop           = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    cur_nxt       = cur_r;
    h_nxt         = h_r;
    load_out      = 1'b0;
    out_hash_nxt  = out_hash_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head.vld) begin
          pop     = 1'b1;
          cur_nxt = head.entry;
          if (head.entry.first) begin
            mul_req.start = 1'b1;
            mul_req.a     = {33'd0, head.entry.length};
          end
        end
      end
      BK_LEN_W: begin
        if (mul_rsp.done) h_nxt = seed ^ res;
      end
      BK_BODY: begin
        if (cur_is_full) begin
          mul_req.start = 1'b1;
          mul_req.a     = cur_r.word;
        end else if (cur_r.kind == IK_TAIL) begin
          mul_req.start = 1'b1;
          mul_req.a     = h_r ^ cur_r.word;
        end
      end
      BK_K1_W: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = res ^ (res >> MIX_SHIFT);
        end
      end
      BK_K2_W: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = h_r ^ res;
        end
      end
      BK_H_W: begin
        if (mul_rsp.done) h_nxt = res;
      end
      BK_FIN: begin
        if (cur_r.last && !out_vld_r) begin
          mul_req.start = 1'b1;
          mul_req.a     = h_r ^ (h_r >> MIX_SHIFT);
        end
      end
      BK_FOUT_W: begin
        if (mul_rsp.done) begin
          load_out     = 1'b1;
          out_hash_nxt = res ^ (res >> MIX_SHIFT);
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      h_r       <= 64'd0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      h_r       <= h_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cur_r      <= cur_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.hash_value = out_hash_r;

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiply issued while the multiplier is busy");

  a_load_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_vld_r)
    else $error("finished hash overwrote a pending result");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == BK_LEN_W || state_r == BK_K1_W ||
                      state_r == BK_K2_W || state_r == BK_H_W ||
                      state_r == BK_FOUT_W))
    else $error("product arrived with no step waiting for it");

endmodule

### rtl/murmur64a_hash_top.sv
// Top level of the streaming MurmurHash64A block: seed register, front end, back end, multiplier.
//
//   channel  | dir | payload                                         | accepted when
//   ---------+-----+-------------------------------------------------+-------------------
//   in_ch    | in  | data_word, valid_bytes, first_word, last_word,  | valid && ready
//            |     | message_length                                  |
//   out_ch   | out | hash_value                                      | valid && ready
//   cfg_ch   | in  | hash_seed                                       | valid && ready
//
// Every multiply by the mixing constant runs on one shared 32x32 multiplier in three
// partial products. In the back end a full word takes three such multiplies, a tail
// one and a word with no valid bytes none; a first word adds a multiply for the
// length product and a last word adds one for the finalizer, with the hash showing
// on out_ch as the back end returns to idle.
// Reset is synchronous and active low; it clears the seed, the running hash, the queue
// and all handshake state. There is no clearing pass.
// The front end takes words into a two-word queue while the back end works, so input
// stalls only when the queue is full; a held result on out_ch stalls only the
// finalizer of the next message.
module murmur64a_hash_top
  import mh64_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mh64_in_if.sink    in_ch,
  mh64_out_if.source out_ch,
  mh64_cfg_if.sink   cfg_ch
);

  logic [31:0] seed_r, seed_nxt;
  q_head_t     head;
  logic        pop;
  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  // Always ready, unguarded: the user must write the seed register only while the block is idle.
  assign cfg_ch.ready = 1'b1;
  assign seed_nxt     = cfg_ch.valid ? cfg_ch.hash_seed : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  // The front end masks bytes past the valid count and tags each word as full, tail
  // or empty, so the back end only has to choose among three update sequences.
  mh64_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  // The back end owns the running hash and the result register on out_ch.
  mh64_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .seed    ({32'd0, seed_r}),
    .head    (head),
    .pop     (pop),
    .mul_req (mul_req),
    .mul_rsp (mul_rsp),
    .out_ch  (out_ch)
  );

  // Shared multiplier: every product in the hash is by the same 64-bit constant.
  mh64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

endmodule
